/* rtl/core/kacl_pkg.sv */
`default_nettype none

package kacl_pkg;

    // table geometry
    localparam int TABLE_ENTRIES = 48;
    localparam int KEY_BITS      = 64;
    localparam int IDX_W         = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;

    // front to back queue
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic ACTION_RATE = 1'b0;
    localparam logic ACTION_ONCE = 1'b1;

    // classified request as it travels through the queue
    typedef struct packed {
        logic                action;
        logic [KEY_BITS-1:0] key;
        logic [31:0]         now_ms;
        logic [31:0]         min_gap_ms;
        logic                key_empty;
    } item_t;

    // one table record
    typedef struct packed {
        logic [KEY_BITS-1:0] key;
        logic [31:0]         last_time;
        logic [31:0]         suppressed;
        logic                once_done;
    } rec_t;

    // push and full flags between the front part and the queue
    typedef struct packed {
        logic push;
        logic full;
    } q_ctrl_t;

    typedef enum logic [1:0] {
        BACK_IDLE,
        BACK_READ,
        BACK_CHECK,
        BACK_DONE
    } back_state_t;

endpackage

`default_nettype wire

/* rtl/core/kacl_front.sv */
`default_nettype none

module kacl_front (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  in_valid,
    output logic                       in_stall,
    input  wire logic                  action,
    input  wire logic [63:0]           key_tag,
    input  wire logic [31:0]           now_ms,
    input  wire logic [31:0]           min_gap_ms,
    input  wire logic                  q_full,
    output logic                       q_push,
    output kacl_pkg::item_t            push_item
);

    logic            hold_valid_reg;
    kacl_pkg::item_t hold_item_reg;
    kacl_pkg::item_t item_next;
    logic            accept;

    assign in_stall  = hold_valid_reg && q_full;
    assign accept    = in_valid && !in_stall;
    assign q_push    = hold_valid_reg && !q_full;
    assign push_item = hold_item_reg;

    // mask off unused key bits and flag the empty key
    always_comb
    begin
        item_next.action     = action;
        item_next.key        = key_tag[kacl_pkg::KEY_BITS-1:0];
        item_next.now_ms     = now_ms;
        item_next.min_gap_ms = min_gap_ms;
        item_next.key_empty  = (key_tag[kacl_pkg::KEY_BITS-1:0] == '0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hold_valid_reg <= 1'b0;
        end
        else if (accept)
        begin
            hold_valid_reg <= 1'b1;
        end
        else if (q_push)
        begin
            hold_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            hold_item_reg <= item_next;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kacl_queue.sv */
`default_nettype none

module kacl_queue (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire kacl_pkg::q_ctrl_t     ctrl_in,
    input  wire kacl_pkg::item_t       push_item,
    output logic                       full,
    input  wire logic                  pop,
    output logic                       pop_valid,
    output kacl_pkg::item_t            pop_item
);

    kacl_pkg::item_t                    slots_reg [kacl_pkg::QUEUE_DEPTH];
    logic [kacl_pkg::QPTR_W-1:0]        wr_ptr_reg;
    logic [kacl_pkg::QPTR_W-1:0]        rd_ptr_reg;
    logic [kacl_pkg::QCNT_W-1:0]        count_reg;
    logic                               do_push;
    logic                               do_pop;

    assign full      = (count_reg == kacl_pkg::QCNT_W'(kacl_pkg::QUEUE_DEPTH));
    assign pop_valid = (count_reg != '0);
    assign pop_item  = slots_reg[rd_ptr_reg];
    assign do_push   = ctrl_in.push && !full;
    assign do_pop    = pop && pop_valid;

    function automatic logic [kacl_pkg::QPTR_W-1:0] ptr_inc(
        input logic [kacl_pkg::QPTR_W-1:0] p
    );
        if (p == kacl_pkg::QPTR_W'(kacl_pkg::QUEUE_DEPTH - 1))
        begin
            return '0;
        end
        return p + 1'b1;
    endfunction

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= ptr_inc(wr_ptr_reg);
            end
            if (do_pop)
            begin
                rd_ptr_reg <= ptr_inc(rd_ptr_reg);
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots_reg[wr_ptr_reg] <= push_item;
        end
    end

endmodule

`default_nettype wire

/* rtl/core/kacl_back.sv */
`default_nettype none

module kacl_back (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    input  wire logic                  pop_valid,
    input  wire kacl_pkg::item_t       pop_item,
    output logic                       pop,
    output logic                       out_valid,
    input  wire logic                  out_stall,
    output logic                       allow,
    output logic [31:0]                suppressed_count,
    output logic                       fail_open
);

    localparam logic [kacl_pkg::IDX_W-1:0] LAST_IDX =
        kacl_pkg::IDX_W'(kacl_pkg::TABLE_ENTRIES - 1);

    kacl_pkg::back_state_t              state_reg, state_next;
    kacl_pkg::item_t                    item_reg;
    logic [kacl_pkg::IDX_W-1:0]         idx_reg;
    logic                               found_reg;
    logic                               free_found_reg;
    logic [kacl_pkg::IDX_W-1:0]         free_idx_reg;
    logic [kacl_pkg::TABLE_ENTRIES-1:0] valid_reg;
    kacl_pkg::rec_t                     rd_data_reg;
    kacl_pkg::rec_t                     rec_mem [kacl_pkg::TABLE_ENTRIES];

    logic                               out_valid_reg;
    logic                               allow_reg;
    logic [31:0]                        count_reg;
    logic                               fail_reg;

    logic                               out_free;
    logic                               hit;
    logic                               wr_en;
    logic                               have_slot;
    logic [kacl_pkg::IDX_W-1:0]         slot;
    kacl_pkg::rec_t                     rec_cur;
    kacl_pkg::rec_t                     rec_new;
    logic [31:0]                        elapsed;
    logic                               rate_ok;
    logic                               allow_next;
    logic [31:0]                        count_next;
    logic                               fail_next;

    assign out_free = !out_valid_reg || !out_stall;
    assign hit      = valid_reg[idx_reg] && (rd_data_reg.key == item_reg.key);

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            kacl_pkg::BACK_IDLE:
            begin
                if (pop_valid)
                begin
                    state_next = pop_item.key_empty ? kacl_pkg::BACK_DONE
                                                    : kacl_pkg::BACK_READ;
                end
            end
            kacl_pkg::BACK_READ:
            begin
                state_next = kacl_pkg::BACK_CHECK;
            end
            kacl_pkg::BACK_CHECK:
            begin
                if (hit || idx_reg == LAST_IDX)
                begin
                    state_next = kacl_pkg::BACK_DONE;
                end
                else
                begin
                    state_next = kacl_pkg::BACK_READ;
                end
            end
            kacl_pkg::BACK_DONE:
            begin
                if (out_free)
                begin
                    state_next = kacl_pkg::BACK_IDLE;
                end
            end
            default:
            begin
                state_next = kacl_pkg::BACK_IDLE;
            end
        endcase
    end

    // control outputs
    always_comb
    begin
        pop   = 1'b0;
        wr_en = 1'b0;
        unique case (state_reg)
            kacl_pkg::BACK_IDLE:  pop   = pop_valid;
            kacl_pkg::BACK_DONE:  wr_en = out_free && have_slot;
            default:
            begin
                pop   = 1'b0;
                wr_en = 1'b0;
            end
        endcase
    end

    // record update and result
    always_comb
    begin
        have_slot = !item_reg.key_empty && (found_reg || free_found_reg);
        slot      = found_reg ? idx_reg : free_idx_reg;
        if (found_reg)
        begin
            rec_cur = rd_data_reg;
        end
        else
        begin
            rec_cur.key        = item_reg.key;
            rec_cur.last_time  = '0;
            rec_cur.suppressed = '0;
            rec_cur.once_done  = 1'b0;
        end
        elapsed    = item_reg.now_ms - rec_cur.last_time;
        rate_ok    = (rec_cur.last_time == '0) || (elapsed >= item_reg.min_gap_ms);
        rec_new    = rec_cur;
        allow_next = 1'b0;
        count_next = '0;
        fail_next  = 1'b0;
        if (!have_slot)
        begin
            allow_next = 1'b1;
            fail_next  = 1'b1;
        end
        else if (item_reg.action == kacl_pkg::ACTION_RATE)
        begin
            if (rate_ok)
            begin
                allow_next         = 1'b1;
                count_next         = rec_cur.suppressed;
                rec_new.suppressed = '0;
                rec_new.last_time  = item_reg.now_ms;
            end
            else
            begin
                rec_new.suppressed = rec_cur.suppressed + 32'd1;
            end
        end
        else if (!rec_cur.once_done)
        begin
            rec_new.once_done = 1'b1;
            allow_next        = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= kacl_pkg::BACK_IDLE;
            valid_reg      <= '0;
            found_reg      <= 1'b0;
            free_found_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (pop)
            begin
                found_reg      <= 1'b0;
                free_found_reg <= 1'b0;
            end
            if (state_reg == kacl_pkg::BACK_CHECK)
            begin
                if (hit)
                begin
                    found_reg <= 1'b1;
                end
                if (!valid_reg[idx_reg] && !free_found_reg)
                begin
                    free_found_reg <= 1'b1;
                end
            end
            if (wr_en)
            begin
                valid_reg[slot] <= 1'b1;
            end
            if (state_reg == kacl_pkg::BACK_DONE && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // payload and scan index
    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            item_reg <= pop_item;
            idx_reg  <= '0;
        end
        else if (state_reg == kacl_pkg::BACK_CHECK && !hit && idx_reg != LAST_IDX)
        begin
            idx_reg <= idx_reg + 1'b1;
        end
        if (state_reg == kacl_pkg::BACK_CHECK && !valid_reg[idx_reg] && !free_found_reg)
        begin
            free_idx_reg <= idx_reg;
        end
        if (state_reg == kacl_pkg::BACK_DONE && out_free)
        begin
            allow_reg <= allow_next;
            count_reg <= count_next;
            fail_reg  <= fail_next;
        end
    end

    // record memory, one read and one write port
    always_ff @(posedge clk)
    begin
        if (state_reg == kacl_pkg::BACK_READ)
        begin
            rd_data_reg <= rec_mem[idx_reg];
        end
        if (wr_en)
        begin
            rec_mem[slot] <= rec_new;
        end
    end

    assign out_valid        = out_valid_reg;
    assign allow            = allow_reg;
    assign suppressed_count = count_reg;
    assign fail_open        = fail_reg;

    a_refused_clean: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !allow_reg |-> !fail_reg && count_reg == '0)
        else $error("refused result carries count or fail flag");

    a_fail_allows: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && fail_reg |-> allow_reg && count_reg == '0)
        else $error("fail-open result not allowed");

    a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kacl_pkg::BACK_CHECK |-> idx_reg <= LAST_IDX)
        else $error("scan index past table end");

    a_hit_key: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kacl_pkg::BACK_DONE && found_reg
            |-> rd_data_reg.key == item_reg.key && valid_reg[idx_reg])
        else $error("matched record does not hold the key");

    a_empty_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == kacl_pkg::BACK_DONE && item_reg.key_empty |-> !wr_en)
        else $error("empty key wrote the table");

endmodule

`default_nettype wire

/* rtl/core/keyed_alert_cooldown_limiter_unit.sv */
// channel | valid     | stall     | payload
// input   | in_valid  | in_stall  | action, key_tag, now_ms, min_gap_ms
// output  | out_valid | out_stall | allow, suppressed_count, fail_open
//
// a transaction with an empty key skips the scan: the back part goes from idle straight to done
// a keyed transaction scans the record memory one entry at a time, a read then a compare per entry,
// stopping at a match or after the last entry
// the one-read-port record memory and its scan loop set how long the scan takes
// reset clears the entry valid bits at once; no clearing pass is needed
// a stalled output holds the back part, the queue then fills and stalls input
`default_nettype none

module keyed_alert_cooldown_limiter_unit (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        in_valid,
    output logic             in_stall,
    input  wire logic        action,
    input  wire logic [63:0] key_tag,
    input  wire logic [31:0] now_ms,
    input  wire logic [31:0] min_gap_ms,
    output logic             out_valid,
    input  wire logic        out_stall,
    output logic             allow,
    output logic [31:0]      suppressed_count,
    output logic             fail_open
);

    // front to queue
    kacl_pkg::q_ctrl_t q_ctrl;
    kacl_pkg::item_t   push_item;
    logic              q_push;
    logic              q_full;

    // queue to back
    logic              q_pop;
    logic              q_pop_valid;
    kacl_pkg::item_t   q_pop_item;

    always_comb
    begin
        q_ctrl.push = q_push;
        q_ctrl.full = q_full;
    end

    // front: registers the transaction, masks the key, flags the empty key
    kacl_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .action      (action),
        .key_tag     (key_tag),
        .now_ms      (now_ms),
        .min_gap_ms  (min_gap_ms),
        .q_full      (q_ctrl.full),
        .q_push      (q_push),
        .push_item   (push_item)
    );

    // short queue so the front keeps taking transactions while the back scans
    kacl_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctrl_in   (q_ctrl),
        .push_item (push_item),
        .full      (q_full),
        .pop       (q_pop),
        .pop_valid (q_pop_valid),
        .pop_item  (q_pop_item)
    );

    // back: table scan, allocation, cooldown / once decision, output register
    kacl_back u_back (
        .clk              (clk),
        .rst_n            (rst_n),
        .pop_valid        (q_pop_valid),
        .pop_item         (q_pop_item),
        .pop              (q_pop),
        .out_valid        (out_valid),
        .out_stall        (out_stall),
        .allow            (allow),
        .suppressed_count (suppressed_count),
        .fail_open        (fail_open)
    );

endmodule

`default_nettype wire
